[rtl/lhm_pkg.sv]
// Shared types, codes and reset values of the link heartbeat monitor.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package lhm_pkg;

    localparam int LINK_W            = 4;
    localparam int TIME_W            = 32;
    localparam int CNT_W             = 8;
    localparam int ST_W              = 3;
    localparam int CMD_W             = 3;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int DEFAULT_NUM_LINKS = 16;
    localparam int QUEUE_DEPTH       = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SWEEP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PING_RX = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PONG_RX = 3'd4;
    localparam logic [CMD_W-1:0] CMD_OUTCOME = 3'd5;

    // Link status codes.
    localparam logic [ST_W-1:0] ST_UNKNOWN      = 3'd0;
    localparam logic [ST_W-1:0] ST_CONNECTED    = 3'd1;
    localparam logic [ST_W-1:0] ST_MISSING      = 3'd2;
    localparam logic [ST_W-1:0] ST_DISCONNECTED = 3'd3;
    localparam logic [ST_W-1:0] ST_CONNECTING   = 3'd4;
    localparam logic [ST_W-1:0] ST_FAILED       = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_INTERVAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECEIVE_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_ENABLE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCH_ENABLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_RETRY      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT     = 3'd7;

    localparam logic [TIME_W-1:0] RST_SEND_INTERVAL   = 32'd30000;
    localparam logic [TIME_W-1:0] RST_RECEIVE_TIMEOUT = 32'd90000;
    localparam logic [CNT_W-1:0]  RST_MISS_LIMIT      = 8'd3;
    localparam logic [TIME_W-1:0] RST_RETRY_DELAY     = 32'd5000;
    localparam logic [CNT_W-1:0]  RST_RETRY_LIMIT     = 8'd10;

    typedef struct packed {
        logic [TIME_W-1:0] send_interval_ms;
        logic [TIME_W-1:0] receive_timeout_ms;
        logic [CNT_W-1:0]  miss_limit;
        logic              ping_enable;
        logic              watch_enable;
        logic              auto_retry;
        logic [TIME_W-1:0] retry_delay_ms;
        logic [CNT_W-1:0]  retry_limit;
    } t_cfg;

    // One classified input word as it waits in the queue.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [LINK_W-1:0] link;
        logic              in_range;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] seq_in;
        logic              retry_ok;
    } t_item;

    typedef struct packed {
        logic              valid;
        t_item             item;
    } t_queue_out;

    // One row of the link table.
    typedef struct packed {
        logic              present;
        logic [ST_W-1:0]   status;
        logic [TIME_W-1:0] last_send_time;
        logic [TIME_W-1:0] last_receive_time;
        logic [TIME_W-1:0] last_seen_seq;
        logic [TIME_W-1:0] next_ping_seq;
        logic [CNT_W-1:0]  misses;
        logic [CNT_W-1:0]  attempts;
    } t_entry;

endpackage
`default_nettype wire

[rtl/lhm_cfg.sv]
// Configuration register file of the link heartbeat monitor.
// Depends on lhm_pkg.
`default_nettype none
module lhm_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lhm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lhm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output lhm_pkg::t_cfg                      o_cfg
);
    import lhm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.send_interval_ms   <= RST_SEND_INTERVAL;
            r_cfg.receive_timeout_ms <= RST_RECEIVE_TIMEOUT;
            r_cfg.miss_limit         <= RST_MISS_LIMIT;
            r_cfg.ping_enable        <= 1'b1;
            r_cfg.watch_enable       <= 1'b1;
            r_cfg.auto_retry         <= 1'b1;
            r_cfg.retry_delay_ms     <= RST_RETRY_DELAY;
            r_cfg.retry_limit        <= RST_RETRY_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEND_INTERVAL:   r_cfg.send_interval_ms   <= i_cfg_data[TIME_W-1:0];
                CFG_RECEIVE_TIMEOUT: r_cfg.receive_timeout_ms <= i_cfg_data[TIME_W-1:0];
                CFG_MISS_LIMIT:      r_cfg.miss_limit         <= i_cfg_data[CNT_W-1:0];
                CFG_PING_ENABLE:     r_cfg.ping_enable        <= i_cfg_data[0];
                CFG_WATCH_ENABLE:    r_cfg.watch_enable       <= i_cfg_data[0];
                CFG_AUTO_RETRY:      r_cfg.auto_retry         <= i_cfg_data[0];
                CFG_RETRY_DELAY:     r_cfg.retry_delay_ms     <= i_cfg_data[TIME_W-1:0];
                CFG_RETRY_LIMIT:     r_cfg.retry_limit        <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[rtl/lhm_front.sv]
// Front end: accepts input words, checks the link index against the table
// size and holds them in a short queue for the back end. Depends on lhm_pkg.
`default_nettype none
module lhm_front #(
    parameter int NUM_LINKS = lhm_pkg::DEFAULT_NUM_LINKS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [lhm_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic [lhm_pkg::LINK_W-1:0] i_link,
    input  wire logic [lhm_pkg::TIME_W-1:0] i_now_ms,
    input  wire logic [lhm_pkg::TIME_W-1:0] i_seq_in,
    input  wire logic                       i_retry_ok,
    input  wire logic                       i_hold,
    input  wire logic                       i_pop,
    output lhm_pkg::t_queue_out             o_queue
);
    import lhm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    t_item             in_item;
    logic              push, pop;

    always_comb begin
        in_item.cmd      = i_cmd;
        in_item.link     = i_link;
        in_item.in_range = int'(i_link) < NUM_LINKS;
        in_item.now_ms   = i_now_ms;
        in_item.seq_in   = i_seq_in;
        in_item.retry_ok = i_retry_ok;
    end

    assign o_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH)) && !i_hold;
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_queue.valid = (r_cnt != '0);
    assign o_queue.item  = r_q[r_rp];

endmodule
`default_nettype wire

[rtl/lhm_back.sv]
// Back end: link table memory, per-link read-modify-write of one word at a
// time and the result register. Depends on lhm_pkg.
`default_nettype none
module lhm_back #(
    parameter int NUM_LINKS = lhm_pkg::DEFAULT_NUM_LINKS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  lhm_pkg::t_cfg                i_cfg,
    input  lhm_pkg::t_queue_out          i_queue,
    output logic                         o_pop,
    output logic                         o_clearing,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic                         o_known,
    output logic [lhm_pkg::ST_W-1:0]     o_link_status,
    output logic                         o_status_changed,
    output logic                         o_send_ping,
    output logic [lhm_pkg::TIME_W-1:0]   o_ping_seq,
    output logic                         o_send_pong,
    output logic [lhm_pkg::TIME_W-1:0]   o_pong_seq,
    output logic                         o_retry_request,
    output logic [lhm_pkg::CNT_W-1:0]    o_miss_count
);
    import lhm_pkg::*;

    localparam int ADDR_W = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_clr_cnt;
    logic [ADDR_W-1:0] r_addr;
    t_item             r_item;
    t_entry            r_mem [NUM_LINKS];
    t_entry            r_rd;

    logic              r_valid, r_known, r_changed, r_sp, r_spo, r_rr;
    logic [ST_W-1:0]   r_status;
    logic [TIME_W-1:0] r_ps, r_pos;
    logic [CNT_W-1:0]  r_miss;

    logic [ADDR_W-1:0] rd_addr;
    logic              out_free, exec_done;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_entry            mem_wdata;

    // Execution of one word.
    t_entry            w;
    logic              was, wr_en, now_known, ping_due, timed_out;
    logic              sp, spo, rr;
    logic [TIME_W-1:0] ps, pos, send_gap;
    logic [CNT_W-1:0]  m1;
    logic [ST_W-1:0]   old_st, new_st;

    assign rd_addr   = i_queue.item.in_range ? ADDR_W'(i_queue.item.link) : '0;
    assign o_pop     = (r_state == S_IDLE) && i_queue.valid;
    assign out_free  = !r_valid || i_ready;
    assign exec_done = (r_state == S_EXEC) && out_free;
    assign o_clearing = (r_state == S_CLEAR);

    always_comb begin
        was    = r_item.in_range && r_rd.present;
        old_st = was ? r_rd.status : ST_UNKNOWN;
        w      = r_rd;
        sp     = 1'b0;
        ps     = '0;
        spo    = 1'b0;
        pos    = '0;
        rr     = 1'b0;
        ping_due  = i_cfg.ping_enable &&
                    ((r_item.now_ms - r_rd.last_send_time) >= i_cfg.send_interval_ms);
        timed_out = i_cfg.watch_enable &&
                    ((r_item.now_ms - r_rd.last_receive_time) >= i_cfg.receive_timeout_ms);
        // A ping sent by this sweep restarts the send clock.
        send_gap  = ping_due ? '0 : (r_item.now_ms - r_rd.last_send_time);
        m1        = (r_rd.misses == {CNT_W{1'b1}}) ? r_rd.misses : r_rd.misses + 1'b1;

        if ((r_item.cmd == CMD_ADD) && r_item.in_range) begin
            w.present           = 1'b1;
            w.status            = ST_CONNECTED;
            w.last_send_time    = r_item.now_ms - i_cfg.send_interval_ms;
            w.last_receive_time = r_item.now_ms;
            w.last_seen_seq     = '0;
            w.next_ping_seq     = TIME_W'(1);
            w.misses            = '0;
            w.attempts          = '0;
        end else if (was) begin
            case (r_item.cmd)
                CMD_REMOVE: begin
                    w.present = 1'b0;
                end
                CMD_SWEEP: begin
                    if (ping_due) begin
                        sp              = 1'b1;
                        ps              = r_rd.next_ping_seq;
                        w.next_ping_seq = r_rd.next_ping_seq + 1'b1;
                        w.last_send_time = r_item.now_ms;
                    end
                    if (timed_out) begin
                        w.misses = m1;
                        if (m1 >= i_cfg.miss_limit) begin
                            if ((r_rd.status == ST_CONNECTED) ||
                                (r_rd.status == ST_MISSING)) begin
                                w.status = ST_DISCONNECTED;
                                if (i_cfg.auto_retry) begin
                                    if (r_rd.attempts >= i_cfg.retry_limit) begin
                                        w.status = ST_FAILED;
                                    end else if (send_gap >= i_cfg.retry_delay_ms) begin
                                        w.attempts = r_rd.attempts + 1'b1;
                                        w.status   = ST_CONNECTING;
                                        rr         = 1'b1;
                                    end
                                end
                            end
                        end else if (r_rd.status == ST_CONNECTED) begin
                            w.status = ST_MISSING;
                        end
                    end
                end
                CMD_PING_RX: begin
                    spo = 1'b1;
                    pos = r_item.seq_in;
                end
                CMD_PONG_RX: begin
                    w.last_receive_time = r_item.now_ms;
                    w.last_seen_seq     = r_item.seq_in;
                    w.misses            = '0;
                    w.status            = ST_CONNECTED;
                end
                CMD_OUTCOME: begin
                    if (r_rd.status == ST_CONNECTING) begin
                        if (r_item.retry_ok) begin
                            w.misses            = '0;
                            w.last_receive_time = r_item.now_ms;
                            w.status            = ST_CONNECTED;
                        end else begin
                            w.last_send_time = r_item.now_ms;
                        end
                    end
                end
                default: ;
            endcase
        end

        wr_en     = r_item.in_range && ((r_item.cmd == CMD_ADD) || was);
        now_known = r_item.in_range && w.present;
        new_st    = now_known ? w.status : ST_UNKNOWN;
    end

    // The table is swept to absent after reset, one row a cycle.
    always_comb begin
        mem_we    = o_clearing || (exec_done && wr_en);
        mem_waddr = o_clearing ? r_clr_cnt : r_addr;
        mem_wdata = o_clearing ? t_entry'('0) : w;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (o_pop) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (exec_done) begin
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_cnt == ADDR_W'(NUM_LINKS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr_cnt <= r_clr_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_queue.valid) begin
                        r_item  <= i_queue.item;
                        r_addr  <= rd_addr;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_known   <= now_known;
                        r_status  <= new_st;
                        r_changed <= (new_st != old_st);
                        r_sp      <= sp;
                        r_ps      <= ps;
                        r_spo     <= spo;
                        r_pos     <= pos;
                        r_rr      <= rr;
                        r_miss    <= now_known ? w.misses : '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_known          = r_known;
    assign o_link_status    = r_status;
    assign o_status_changed = r_changed;
    assign o_send_ping      = r_sp;
    assign o_ping_seq       = r_ps;
    assign o_send_pong      = r_spo;
    assign o_pong_seq       = r_pos;
    assign o_retry_request  = r_rr;
    assign o_miss_count     = r_miss;

endmodule
`default_nettype wire

[rtl/link_heartbeat_monitor.sv]
// Top level of the link heartbeat monitor: configuration registers, front
// queue and back end. Depends on lhm_pkg, lhm_cfg, lhm_front and lhm_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | i_valid / o_ready    | cmd, link, now_ms, seq_in, retry_ok
//  result   | o_valid / i_ready    | known, link_status, status_changed,
//           |                      | send_ping, ping_seq, send_pong, pong_seq,
//           |                      | retry_request, miss_count
//  config   | i_cfg_we             | i_cfg_index, i_cfg_data
//
// Each word passes two steps in the back end: a read of the link's table row
// from memory, then an update of the row and a load of the result register,
// which waits while an earlier result waits for i_ready; no new word is taken
// until the last is through. After reset the table is cleared one row a cycle
// with o_ready low. A two-word queue accepts until full while a result waits.
`default_nettype none
module link_heartbeat_monitor #(
    parameter int NUM_LINKS = lhm_pkg::DEFAULT_NUM_LINKS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [lhm_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic [lhm_pkg::LINK_W-1:0]     i_link,
    input  wire logic [lhm_pkg::TIME_W-1:0]     i_now_ms,
    input  wire logic [lhm_pkg::TIME_W-1:0]     i_seq_in,
    input  wire logic                           i_retry_ok,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_known,
    output logic [lhm_pkg::ST_W-1:0]            o_link_status,
    output logic                                o_status_changed,
    output logic                                o_send_ping,
    output logic [lhm_pkg::TIME_W-1:0]          o_ping_seq,
    output logic                                o_send_pong,
    output logic [lhm_pkg::TIME_W-1:0]          o_pong_seq,
    output logic                                o_retry_request,
    output logic [lhm_pkg::CNT_W-1:0]           o_miss_count,
    input  wire logic                           i_cfg_we,
    input  wire logic [lhm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lhm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lhm_pkg::*;

    t_cfg       cfg;
    t_queue_out queue;
    logic       pop, clearing;

    lhm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lhm_front #(
        .NUM_LINKS (NUM_LINKS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_cmd      (i_cmd),
        .i_link     (i_link),
        .i_now_ms   (i_now_ms),
        .i_seq_in   (i_seq_in),
        .i_retry_ok (i_retry_ok),
        .i_hold     (clearing),
        .i_pop      (pop),
        .o_queue    (queue)
    );

    lhm_back #(
        .NUM_LINKS (NUM_LINKS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_queue          (queue),
        .o_pop            (pop),
        .o_clearing       (clearing),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_known          (o_known),
        .o_link_status    (o_link_status),
        .o_status_changed (o_status_changed),
        .o_send_ping      (o_send_ping),
        .o_ping_seq       (o_ping_seq),
        .o_send_pong      (o_send_pong),
        .o_pong_seq       (o_pong_seq),
        .o_retry_request  (o_retry_request),
        .o_miss_count     (o_miss_count)
    );

endmodule
`default_nettype wire
